// ----- rtl/core/amtu_pkg.sv -----
// ----------------------------------------------------------------------------
// amtu_pkg
// Shared types and constants for the affine matrix transform unit.
// ----------------------------------------------------------------------------
package amtu_pkg;

    localparam int ELEMENT_WIDTH = 32;
    localparam int CORDIC_STEPS  = 16;
    localparam int CORDIC_W      = 34;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    typedef enum logic [2:0] {
        CMD_WRITE     = 3'd0,
        CMD_TRANSLATE = 3'd1,
        CMD_SCALE     = 3'd2,
        CMD_ROTATE    = 3'd3,
        CMD_TRANSPOSE = 3'd4,
        CMD_READ      = 3'd5
    } t_cmd;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    typedef struct packed {
        logic [2:0]        command;
        logic [3:0]        index;
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic signed [31:0] value_z;
        logic [15:0]       angle;
        logic [1:0]        axis;
        logic              inverse;
    } t_cmd_item;

    typedef struct packed {
        logic signed [31:0] element;
    } t_res_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_MAC,
        ST_TRANSPOSE,
        ST_RESULT
    } t_state;

    function automatic logic [CORDIC_W-1:0] atan_turns24(input logic [3:0] i);
        logic [CORDIC_W-1:0] v;
        unique case (i)
            4'd0:  v = 34'd2097152;
            4'd1:  v = 34'd1238021;
            4'd2:  v = 34'd654136;
            4'd3:  v = 34'd332050;
            4'd4:  v = 34'd166669;
            4'd5:  v = 34'd83416;
            4'd6:  v = 34'd41718;
            4'd7:  v = 34'd20860;
            4'd8:  v = 34'd10430;
            4'd9:  v = 34'd5215;
            4'd10: v = 34'd2608;
            4'd11: v = 34'd1304;
            4'd12: v = 34'd652;
            4'd13: v = 34'd326;
            4'd14: v = 34'd163;
            default: v = 34'd81;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/amtu_if.sv -----
// ----------------------------------------------------------------------------
// amtu_cmd_if / amtu_res_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface amtu_cmd_if;
    logic                 valid;
    logic                 ready;
    amtu_pkg::t_cmd_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface amtu_res_if;
    logic                 valid;
    logic                 ready;
    amtu_pkg::t_res_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/affine_matrix_transform_unit.sv -----
// ----------------------------------------------------------------------------
// affine_matrix_transform_unit
// 4x4 Q16.16 matrix kept in registers and updated in place by commands.
// ----------------------------------------------------------------------------
// One command item is taken at a time; ready is low until its result item is
// taken and in the cycle after. Write, read, translate and transpose finish
// without multiply steps; scale takes twelve multiply steps, and rotation
// takes sixteen CORDIC steps, a latch of sine and cosine, and sixteen
// multiply steps on the single shared 32x32 multiplier. A rotation with the
// unused axis code skips the multiply steps. The result item may wait for
// ready before it is taken. The multiplier and the CORDIC step loop set how
// long scale and rotation take.
module affine_matrix_transform_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    amtu_cmd_if.sink   i_cmd,
    amtu_res_if.source o_res
);
    import amtu_pkg::*;

    t_state r_state, n_state;
    t_cmd_item r_item;
    logic signed [ELEMENT_WIDTH-1:0] r_m [16];
    logic [3:0]  r_cnt;
    logic signed [63:0] r_acc;
    logic signed [31:0] r_c, r_sa, r_sb;
    logic signed [ELEMENT_WIDTH-1:0] r_elem_a;
    logic        r_ovalid;

    logic        w_cstart, w_cdone;
    logic signed [31:0] w_cos, w_sin, w_s;
    logic [1:0]  w_ra, w_rb;
    logic [3:0]  w_ia, w_ib, w_widx;
    logic signed [ELEMENT_WIDTH-1:0] w_mop;
    logic signed [31:0] w_fac;
    logic signed [63:0] w_prod, w_sum;
    logic signed [ELEMENT_WIDTH-1:0] w_res;
    logic        w_accept;

    assign w_accept  = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == ST_IDLE);
    assign o_res.valid = r_ovalid;
    // The matrix and the index stay put while the result item waits.
    assign o_res.data.element = 32'(r_m[r_item.index]);

    assign w_cstart = w_accept && (t_cmd'(i_cmd.data.command) == CMD_ROTATE);

    amtu_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cstart),
        .i_angle (i_cmd.data.angle),
        .o_done  (w_cdone),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    assign w_s = r_item.inverse ? -w_sin : w_sin;

    // Rotation rows: a is the first row of the pair, b the second.
    always_comb begin
        unique case (r_item.axis)
            AXIS_X:  begin w_ra = 2'd1; w_rb = 2'd2; end
            AXIS_Y:  begin w_ra = 2'd0; w_rb = 2'd2; end
            default: begin w_ra = 2'd0; w_rb = 2'd1; end
        endcase
    end

    // Scale: r_cnt walks the twelve elements. Rotate: r_cnt[3:2] is the
    // column, r_cnt[1:0] picks output row and term.
    always_comb begin
        w_ia = {w_ra, r_cnt[3:2]};
        w_ib = {w_rb, r_cnt[3:2]};
        w_mop = r_m[r_cnt];
        w_fac = r_item.value_x;
        w_widx = r_cnt;
        if (t_cmd'(r_item.command) == CMD_SCALE) begin
            w_mop = r_m[r_cnt];
            unique case (r_cnt[3:2])
                2'd0: w_fac = r_item.value_x;
                2'd1: w_fac = r_item.value_y;
                default: w_fac = r_item.value_z;
            endcase
            w_widx = r_cnt;
        end else begin
            unique case (r_cnt[1:0])
                2'd0: begin w_mop = r_m[w_ia]; w_fac = r_c;  end
                2'd1: begin w_mop = r_m[w_ib]; w_fac = r_sa; end
                2'd2: begin w_mop = r_elem_a;  w_fac = r_sb; end
                default: begin w_mop = r_m[w_ib]; w_fac = r_c; end
            endcase
            w_widx = r_cnt[1] ? w_ib : w_ia;
        end
        w_prod = 64'(w_mop) * 64'(w_fac);
        w_sum  = r_acc + w_prod;
        w_res  = ELEMENT_WIDTH'((w_sum + 64'sd32768) >>> 16);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) begin
                unique case (t_cmd'(i_cmd.data.command))
                    CMD_SCALE:     n_state = ST_MAC;
                    CMD_ROTATE:    n_state = ST_CORDIC;
                    CMD_TRANSPOSE: n_state = ST_TRANSPOSE;
                    default:       n_state = ST_RESULT;
                endcase
            end
            ST_CORDIC: if (w_cdone) n_state = (r_item.axis == AXIS_NONE) ? ST_RESULT : ST_MAC;
            ST_MAC: if (r_cnt == 4'd15 || (t_cmd'(r_item.command) == CMD_SCALE
                                          && r_cnt == 4'd11)) n_state = ST_RESULT;
            ST_TRANSPOSE: n_state = ST_RESULT;
            ST_RESULT: if (!r_ovalid) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            for (int k = 0; k < 16; k++) r_m[k] <= '0;
        end else begin
            r_state <= n_state;
            if (o_res.valid && o_res.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: if (w_accept) begin
                    r_item <= i_cmd.data;
                    r_cnt  <= '0;
                    r_acc  <= '0;
                    if (t_cmd'(i_cmd.data.command) == CMD_WRITE)
                        r_m[i_cmd.data.index] <= ELEMENT_WIDTH'(i_cmd.data.value_x);
                    if (t_cmd'(i_cmd.data.command) == CMD_TRANSLATE) begin
                        r_m[3]  <= r_m[3]  + ELEMENT_WIDTH'(i_cmd.data.value_x);
                        r_m[7]  <= r_m[7]  + ELEMENT_WIDTH'(i_cmd.data.value_y);
                        r_m[11] <= r_m[11] + ELEMENT_WIDTH'(i_cmd.data.value_z);
                    end
                end
                ST_CORDIC: begin
                    r_c  <= w_cos;
                    r_sa <= (r_item.axis == AXIS_Y) ? w_s : -w_s;
                    r_sb <= (r_item.axis == AXIS_Y) ? -w_s : w_s;
                end
                ST_MAC: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (t_cmd'(r_item.command) == CMD_SCALE) begin
                        r_m[w_widx] <= w_res;
                    end else begin
                        unique case (r_cnt[1:0])
                            2'd0: begin
                                r_acc <= w_prod;
                                r_elem_a <= r_m[w_ia];
                            end
                            2'd1: begin
                                r_m[w_ia] <= w_res;
                                r_acc <= '0;
                            end
                            2'd2: r_acc <= w_prod;
                            default: begin
                                r_m[w_ib] <= w_res;
                                r_acc <= '0;
                            end
                        endcase
                    end
                end
                ST_TRANSPOSE: begin
                    for (int a = 0; a < 4; a++)
                        for (int b = 0; b < 4; b++)
                            r_m[a*4+b] <= r_m[b*4+a];
                end
                default: ;
            endcase
            // The result item becomes valid on the way into the result state.
            if (r_state != ST_RESULT && n_state == ST_RESULT) r_ovalid <= 1'b1;
            if (r_state == ST_RESULT && r_ovalid && !(o_res.valid && o_res.ready))
                r_ovalid <= 1'b1;
        end
    end
endmodule

// ----- rtl/core/amtu_cordic.sv -----
// ----------------------------------------------------------------------------
// amtu_cordic
// Iterative CORDIC: one shared add/shift step per cycle, sixteen steps.
// ----------------------------------------------------------------------------
module amtu_cordic (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [15:0]          i_angle,
    output logic                 o_done,
    output logic signed [31:0]   o_cos,
    output logic signed [31:0]   o_sin
);
    import amtu_pkg::*;

    logic signed [CORDIC_W-1:0] r_x, r_y, r_z, n_x, n_y, n_z;
    logic [4:0]  r_step;
    logic        r_busy;
    logic [1:0]  r_quad;
    logic signed [CORDIC_W-1:0] w_dx, w_dy, w_ca, w_sa;
    logic signed [31:0] w_c, w_s;

    always_comb begin
        w_dx = r_y >>> r_step[3:0];
        w_dy = r_x >>> r_step[3:0];
        if (!r_z[CORDIC_W-1]) begin
            n_x = r_x - w_dx;
            n_y = r_y + w_dy;
            n_z = r_z - signed'(atan_turns24(r_step[3:0]));
        end else begin
            n_x = r_x + w_dx;
            n_y = r_y - w_dy;
            n_z = r_z + signed'(atan_turns24(r_step[3:0]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 5'd1;
            if (r_step == 5'(CORDIC_STEPS - 1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_GAIN_Q30;
            r_y    <= '0;
            r_z    <= CORDIC_W'({i_angle[13:0], 8'd0});
            r_quad <= i_angle[15:14];
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_done = !r_busy;

    always_comb begin
        w_ca = (r_x + 34'sd8192) >>> 14;
        w_sa = (r_y + 34'sd8192) >>> 14;
        if (w_ca > 34'sd65536) w_c = 32'sd65536;
        else if (w_ca < -34'sd65536) w_c = -32'sd65536;
        else w_c = w_ca[31:0];
        if (w_sa > 34'sd65536) w_s = 32'sd65536;
        else if (w_sa < -34'sd65536) w_s = -32'sd65536;
        else w_s = w_sa[31:0];
        unique case (r_quad)
            2'd0: begin o_cos = w_c;  o_sin = w_s;  end
            2'd1: begin o_cos = -w_s; o_sin = w_c;  end
            2'd2: begin o_cos = -w_c; o_sin = -w_s; end
            default: begin o_cos = w_s; o_sin = -w_c; end
        endcase
    end
endmodule

// ----- rtl/core/amtu_checker.sv -----
// ----------------------------------------------------------------------------
// amtu_checker
// Port-level checks of the command and result handshakes.
// ----------------------------------------------------------------------------
module amtu_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_cv,
    input logic i_cr,
    input logic i_rv,
    input logic i_rr,
    input logic [31:0] i_rd
);
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cv && i_cr) |=> !i_cr) else $error("command taken while busy");
    a_no_ready_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rv |-> !i_cr) else $error("ready while result pending");
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rv && !i_rr) |=> (i_rv && $stable(i_rd))) else $error("result dropped");
endmodule

bind affine_matrix_transform_unit amtu_checker u_amtu_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_cv(i_cmd.valid), .i_cr(i_cmd.ready),
    .i_rv(o_res.valid), .i_rr(o_res.ready), .i_rd(o_res.data.element)
);
